FILE: rtl/core/wendland_c2_kernel_eval_unit_assert.svh
// Assertion macros shared by the checker of the Wendland C2 kernel unit.
`ifndef WENDLAND_C2_KERNEL_EVAL_UNIT_ASSERT_SVH
`define WENDLAND_C2_KERNEL_EVAL_UNIT_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define WCK_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked during reset.
`define WCK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/wck_pkg.sv
// Package of shared types and constants for the Wendland C2 kernel unit.
`default_nettype none
package wck_pkg;

   localparam int COMPONENT_BITS_DEFAULT = 32;
   localparam int KERNEL_W = 47;
   localparam int GRAD_W   = 48;
   localparam int CSR_DATA_W  = 48;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_DIMENSION      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF_RADIUS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INV_SMOOTH_LEN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_NORM    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRADIENT_NORM  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZERO_AT_ORIGIN = 3'd5;

   localparam logic [1:0]  DIMENSION_RESET     = 2'd2;
   localparam logic [1:0]  DIMENSION_3D        = 2'd3;
   localparam logic [31:0] CUTOFF_RESET        = 32'd3355443;
   localparam logic [31:0] INV_SMOOTH_RESET    = 32'd655360;
   localparam logic [46:0] KERNEL_NORM_RESET   = 47'd934561821;
   localparam logic [47:0] GRAD_NORM_RESET     = -48'sd467280910824;

   // Square root: one result bit per step, two steps per stage.
   localparam int SQRT_BITS     = 32;
   localparam int SQRT_PER_ST   = 2;
   localparam int SQRT_STAGES   = SQRT_BITS / SQRT_PER_ST;

   // Partial state of the digit-by-digit square root.
   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] root;
   } sqrt_type;

   // Per-beat information that travels down the pipeline with the data.
   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic             big;
      logic             is3d;
      logic             in_sup;
      logic             at_origin;
   } info_type;

   function automatic sqrt_type sqrt_step(sqrt_type s, int k);
      logic [65:0] trial;
      sqrt_type    r;
      trial = (66'(s.root) << (k + 1)) | (66'(1) << (2 * k));
      r = s;
      if (66'(s.rem) >= trial) begin
         r.rem  = s.rem - trial[63:0];
         r.root = s.root | (32'(1) << k);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/wendland_c2_kernel_eval_unit.sv
// Top level of the pipelined Wendland C2 kernel and gradient evaluator.
`default_nettype none
// The unit takes one displacement beat per clock and returns one result beat per clock
// while the output is not stalled. The depth is set mainly by the square root, which
// resolves two bits of the length in each of sixteen stages, followed by the polynomial
// multiplies, whose wide products are split into 32-bit partial products over two
// stages. The whole pipeline advances together whenever the output register is empty
// or being taken, so req_ready follows rsp_ready while a result is waiting.
// Configuration must only be written while no beat is in flight.
module wendland_c2_kernel_eval_unit
   import wck_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [COMPONENT_BITS-1:0] req_disp_x,
   input  wire logic [COMPONENT_BITS-1:0] req_disp_y,
   input  wire logic [COMPONENT_BITS-1:0] req_disp_z,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic [KERNEL_W-1:0]            rsp_kernel_value,
   output logic [GRAD_W-1:0]              rsp_grad_x,
   output logic [GRAD_W-1:0]              rsp_grad_y,
   output logic [GRAD_W-1:0]              rsp_grad_z,
   output logic                           rsp_in_support,
   input  wire logic                      csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int MAG_W    = (COMPONENT_BITS > 32) ? COMPONENT_BITS : 33;
   localparam int ST_MAG   = 0;
   localparam int ST_SQ    = 1;
   localparam int ST_SUM   = 2;
   localparam int ST_RT0   = 3;
   localparam int ST_RTL   = ST_RT0 + SQRT_STAGES - 1;
   localparam int ST_QF    = ST_RTL + 1;
   localparam int ST_OUT   = ST_QF + 8;
   localparam int NUM_ST   = ST_OUT + 1;

   // Configuration registers.
   logic [1:0]          dimension_ff;
   logic [31:0]         cutoff_ff;
   logic [31:0]         inv_len_ff;
   logic [KERNEL_W-1:0] kernel_norm_ff;
   logic [GRAD_W-1:0]   grad_norm_ff;
   logic                zero_origin_ff;
   logic [GRAD_W-1:0]   grad_abs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff   <= DIMENSION_RESET;
         cutoff_ff      <= CUTOFF_RESET;
         inv_len_ff     <= INV_SMOOTH_RESET;
         kernel_norm_ff <= KERNEL_NORM_RESET;
         grad_norm_ff   <= GRAD_NORM_RESET;
         zero_origin_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DIMENSION:      dimension_ff   <= csr_wdata[1:0];
            CSR_CUTOFF_RADIUS:  cutoff_ff      <= csr_wdata[31:0];
            CSR_INV_SMOOTH_LEN: inv_len_ff     <= csr_wdata[31:0];
            CSR_KERNEL_NORM:    kernel_norm_ff <= csr_wdata[KERNEL_W-1:0];
            CSR_GRADIENT_NORM:  grad_norm_ff   <= csr_wdata[GRAD_W-1:0];
            CSR_ZERO_AT_ORIGIN: zero_origin_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The magnitude of the gradient constant is only needed deep in the pipeline.
   always_ff @(posedge clock) begin
      grad_abs_ff <= grad_norm_ff[GRAD_W-1] ? (~grad_norm_ff + 48'd1) : grad_norm_ff;
   end

   logic                valid_ff [NUM_ST];
   info_type            info_ff  [NUM_ST];
   logic                adv;

   assign adv       = !valid_ff[ST_OUT] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = valid_ff[ST_OUT];

   // Component magnitudes and signs.
   info_type                  info0_in;
   logic [COMPONENT_BITS-1:0] raw   [3];
   logic [COMPONENT_BITS-1:0] mag_c [3];
   logic [MAG_W-1:0]          mag_e [3];
   logic                      is3d;

   assign raw[0] = req_disp_x;
   assign raw[1] = req_disp_y;
   assign raw[2] = req_disp_z;
   assign is3d   = (dimension_ff == DIMENSION_3D);

   always_comb begin
      info0_in           = '0;
      info0_in.is3d      = is3d;
      for (int i = 0; i < 3; i++) begin
         mag_c[i] = raw[i][COMPONENT_BITS-1] ? (~raw[i] + 1'b1) : raw[i];
         mag_e[i] = MAG_W'(mag_c[i]);
         if (i < 2 || is3d) begin
            info0_in.mag[i] = mag_e[i][31:0];
            info0_in.neg[i] = raw[i][COMPONENT_BITS-1];
            info0_in.big    = info0_in.big | (|mag_e[i][MAG_W-1:32]);
         end
      end
   end

   // Squares, their sum and the squared cutoff.
   logic [63:0] square_ff [3];
   logic [63:0] cut2_ff;
   logic [63:0] cut2_d_ff;
   logic [65:0] sum_ff;

   // Support and origin flags join the beat as the square root starts.
   info_type    rt0_in;

   always_comb begin
      rt0_in           = info_ff[ST_SUM];
      rt0_in.in_sup    = !info_ff[ST_SUM].big && (sum_ff[65:64] == 2'd0)
                         && (sum_ff[63:0] < cut2_d_ff);
      rt0_in.at_origin = (sum_ff == '0);
   end

   // Square root stages.
   sqrt_type sq_in [SQRT_STAGES];
   sqrt_type sq_ff [SQRT_STAGES];

   always_comb begin
      for (int s = 0; s < SQRT_STAGES; s++) begin
         sq_in[s] = (s == 0) ? sqrt_type'{rem: sum_ff[63:0], root: '0} : sq_ff[(s == 0) ? 0 : s-1];
         for (int j = 0; j < SQRT_PER_ST; j++) begin
            sq_in[s] = sqrt_step(sq_in[s], SQRT_BITS - 1 - SQRT_PER_ST * s - j);
         end
      end
   end

   // Polynomial in t = 1 - q/2.
   logic [63:0] qf_ff;
   logic [47:0] q_full;
   logic [24:0] q25;
   logic [25:0] t_diff;
   logic [30:0] t30_ff, t30_d_ff;
   logic [26:0] p_ff, p_d1_ff, p_d2_ff;
   logic [61:0] t2_prod, t3_prod, t4_prod;
   logic [30:0] t2_ff, t3_ff, t4_ff;
   logic [57:0] m_prod;
   logic [27:0] m_ff;
   logic [62:0] gp_lo_ff;
   logic [46:0] gp_hi_ff;
   logic [78:0] g_sum;
   logic [GRAD_W-1:0] g_ff;
   logic [59:0] kp_lo_ff;
   logic [42:0] kp_hi_ff;
   logic [74:0] w_full;
   logic [KERNEL_W-1:0] w_ff, w_d_ff;
   logic [63:0] cp_lo_ff [3];
   logic [47:0] cp_hi_ff [3];
   logic [79:0] c_full   [3];
   logic [55:0] c_ff     [3];

   assign q_full = qf_ff[63:16];
   assign q25    = q_full[24:0];
   assign t_diff = 26'(33554432) - 26'(q25);
   assign t2_prod = 62'(t30_ff) * 62'(t30_ff);
   assign t3_prod = 62'(t2_ff) * 62'(t30_d_ff);
   assign t4_prod = 62'(t2_ff) * 62'(t2_ff);
   assign m_prod  = 58'(t4_ff) * 58'(p_d2_ff);
   assign g_sum   = (79'(gp_hi_ff) << 32) + 79'(gp_lo_ff);
   assign w_full  = (75'(kp_hi_ff) << 32) + 75'(kp_lo_ff);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         c_full[i] = (80'(cp_hi_ff[i]) << 32) + 80'(cp_lo_ff[i]);
      end
   end

   // Final saturation, sign and zero masks.
   logic [GRAD_W-1:0] grad_in [3];
   logic [GRAD_W-1:0] c_sat   [3];
   logic              sneg    [3];
   logic [KERNEL_W-1:0] kernel_in;
   info_type          fin;

   assign fin = info_ff[ST_OUT-1];

   always_comb begin
      kernel_in = (!fin.in_sup || (fin.at_origin && zero_origin_ff)) ? '0 : w_d_ff;
      for (int i = 0; i < 3; i++) begin
         sneg[i] = grad_norm_ff[GRAD_W-1] ^ fin.neg[i];
         if (sneg[i]) begin
            c_sat[i] = ((|c_ff[i][55:48]) || (c_ff[i][47] && (|c_ff[i][46:0])))
                       ? 48'h8000_0000_0000 : c_ff[i][47:0];
            grad_in[i] = ~c_sat[i] + 48'd1;
         end else begin
            c_sat[i]   = (|c_ff[i][55:47]) ? 48'h7FFF_FFFF_FFFF : c_ff[i][47:0];
            grad_in[i] = c_sat[i];
         end
         if (!fin.in_sup || fin.at_origin || (i == 2 && !fin.is3d)) begin
            grad_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_ST; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k < NUM_ST; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         info_ff[0] <= info0_in;
         for (int k = 1; k < NUM_ST; k++) begin
            info_ff[k] <= (k == ST_RT0) ? rt0_in : info_ff[k-1];
         end

         for (int i = 0; i < 3; i++) begin
            square_ff[i] <= 64'(info_ff[ST_MAG].mag[i]) * 64'(info_ff[ST_MAG].mag[i]);
         end
         cut2_ff   <= 64'(cutoff_ff) * 64'(cutoff_ff);
         sum_ff    <= 66'(square_ff[0]) + 66'(square_ff[1]) + 66'(square_ff[2]);
         cut2_d_ff <= cut2_ff;

         for (int s = 0; s < SQRT_STAGES; s++) begin
            sq_ff[s] <= sq_in[s];
         end

         qf_ff    <= 64'(sq_ff[SQRT_STAGES-1].root) * 64'(inv_len_ff);
         t30_ff   <= (|q_full[47:25]) ? '0 : {t_diff, 5'd0};
         p_ff     <= 27'({q25, 1'b0}) + 27'(16777216);
         t2_ff    <= t2_prod[60:30];
         t30_d_ff <= t30_ff;
         p_d1_ff  <= p_ff;
         t3_ff    <= t3_prod[60:30];
         t4_ff    <= t4_prod[60:30];
         p_d2_ff  <= p_d1_ff;
         m_ff     <= m_prod[57:30];
         gp_lo_ff <= 63'(grad_abs_ff[31:0]) * 63'(t3_ff);
         gp_hi_ff <= 47'(grad_abs_ff[47:32]) * 47'(t3_ff);
         kp_lo_ff <= 60'(kernel_norm_ff[31:0]) * 60'(m_ff);
         kp_hi_ff <= 43'(kernel_norm_ff[46:32]) * 43'(m_ff);
         g_ff     <= g_sum[77:30];
         w_ff     <= (|w_full[74:71]) ? '1 : w_full[70:24];
         for (int i = 0; i < 3; i++) begin
            cp_lo_ff[i] <= 64'(g_ff[31:0]) * 64'(info_ff[ST_QF+5].mag[i]);
            cp_hi_ff[i] <= 48'(g_ff[47:32]) * 48'(info_ff[ST_QF+5].mag[i]);
            c_ff[i]     <= c_full[i][79:24];
         end
         w_d_ff   <= w_ff;

         rsp_kernel_value <= kernel_in;
         rsp_grad_x       <= grad_in[0];
         rsp_grad_y       <= grad_in[1];
         rsp_grad_z       <= grad_in[2];
         rsp_in_support   <= fin.in_sup;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/wck_checker.sv
// Port-level checker for the Wendland C2 kernel unit and its bind statement.
`default_nettype none
`include "wendland_c2_kernel_eval_unit_assert.svh"
module wck_checker
   import wck_pkg::*;
#(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEFAULT
) (
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_valid,
   input wire logic                      req_ready,
   input wire logic [COMPONENT_BITS-1:0] req_disp_x,
   input wire logic [COMPONENT_BITS-1:0] req_disp_y,
   input wire logic [COMPONENT_BITS-1:0] req_disp_z,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic [KERNEL_W-1:0]       rsp_kernel_value,
   input wire logic [GRAD_W-1:0]         rsp_grad_x,
   input wire logic [GRAD_W-1:0]         rsp_grad_y,
   input wire logic [GRAD_W-1:0]         rsp_grad_z,
   input wire logic                      rsp_in_support,
   input wire logic                      csr_write_en,
   input wire logic [CSR_INDEX_W-1:0]    csr_index,
   input wire logic [CSR_DATA_W-1:0]     csr_wdata
);

   `WCK_ASSERT_ALWAYS(a_empty_after_reset, clock, reset |=> !rsp_valid, "result beat after reset")

   `WCK_ASSERT(a_outside_zero, clock, reset,
      rsp_valid && !rsp_in_support |-> rsp_kernel_value == '0 && rsp_grad_x == '0
      && rsp_grad_y == '0 && rsp_grad_z == '0, "non-zero result outside support")

   `WCK_ASSERT(a_ready_when_empty, clock, reset, !rsp_valid |-> req_ready,
      "input refused while output register empty")

   `WCK_ASSERT(a_hold_on_stall, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kernel_value)
      && $stable(rsp_grad_x) && $stable(rsp_grad_y) && $stable(rsp_grad_z)
      && $stable(rsp_in_support), "stalled result beat changed")

endmodule

bind wendland_c2_kernel_eval_unit wck_checker #(.COMPONENT_BITS(COMPONENT_BITS)) u_wck_checker (.*);
`default_nettype wire
